>>> rtl/mask_vertical_band_marker_defines.svh
// ----------------------------------------------------------------------------
// mask_vertical_band_marker_defines
// assertion macros shared by the band marker modules
// ----------------------------------------------------------------------------
`ifndef MASK_VERTICAL_BAND_MARKER_DEFINES_SVH
`define MASK_VERTICAL_BAND_MARKER_DEFINES_SVH

// same-cycle implication
`define MVBM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MVBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mvbm_pkg.sv
// ----------------------------------------------------------------------------
// mvbm_pkg
// types and constants of the vertical band marker
// ----------------------------------------------------------------------------
package mvbm_pkg;

   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_HEIGHT_DEF   = 2048;
   localparam int HISTORY_ROWS_DEF = 128;

   localparam int DIM_CFG_W   = 12;
   localparam int TOL_CFG_W   = 5;
   localparam int REACH_CFG_W = 7;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_ADDR_W  = 2;
   localparam int POS_OUT_W   = 11;

   localparam int WIDTH_RST     = 1920;
   localparam int HEIGHT_RST    = 1080;
   localparam int TOLERANCE_RST = 27;
   localparam int REACH_RST     = 96;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_TOLERANCE_ROWS,
      CSR_REACH_ROWS
   } csr_index_type;

   typedef struct packed {
      logic mask_in;
      logic flush;
   } req_type;

   typedef struct packed {
      logic                 mask_out;
      logic [POS_OUT_W-1:0] out_row;
      logic [POS_OUT_W-1:0] out_col;
      logic                 frame_end;
   } rsp_type;

   typedef struct packed {
      logic                 pix;
      logic                 emit;
      logic                 band_b_ok;
      logic                 tol_ok;
      logic                 byp_cur;
      logic                 byp_up;
      logic                 last;
      logic [POS_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] col;
   } stage_type;

endpackage

>>> rtl/mvbm_ram.sv
// ----------------------------------------------------------------------------
// mvbm_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mvbm_ram #(
   parameter int Width = 1,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr_a,
   input  logic [$clog2(Depth)-1:0] rd_addr_b,
   output logic [Width-1:0]         rd_data_a,
   output logic [Width-1:0]         rd_data_b
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_a_ff;
   logic [Width-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/mvbm_csr.sv
// ----------------------------------------------------------------------------
// mvbm_csr
// configuration registers, limited to the usable range (tolerance on output)
// ----------------------------------------------------------------------------
module mvbm_csr import mvbm_pkg::*; #(
   parameter int MaxWidth    = MAX_WIDTH_DEF,
   parameter int MaxHeight   = MAX_HEIGHT_DEF,
   parameter int HistoryRows = HISTORY_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [CSR_ADDR_W-1:0]             csr_addr,
   input  logic [CSR_DATA_W-1:0]             csr_wdata,
   output logic [$clog2(MaxWidth+1)-1:0]     width,
   output logic [$clog2(MaxHeight+1)-1:0]    height,
   output logic [$clog2(HistoryRows)-1:0]    reach,
   output logic [$clog2(HistoryRows)-1:0]    tol
);

   localparam int COL_W   = $clog2(MaxWidth + 1);
   localparam int HGT_W   = $clog2(MaxHeight + 1);
   localparam int LINE_W  = $clog2(HistoryRows);
   localparam int WCMP_W  = (COL_W > DIM_CFG_W) ? COL_W : DIM_CFG_W;
   localparam int HCMP_W  = (HGT_W > DIM_CFG_W) ? HGT_W : DIM_CFG_W;
   localparam int RCMP_W  = (LINE_W > REACH_CFG_W) ? LINE_W : REACH_CFG_W;
   localparam int TCMP_W  = (LINE_W > TOL_CFG_W) ? LINE_W : TOL_CFG_W;

   logic [COL_W-1:0]     width_ff;
   logic [HGT_W-1:0]     height_ff;
   logic [LINE_W-1:0]    reach_ff;
   logic [TOL_CFG_W-1:0] tol_ff;
   logic [TCMP_W-1:0]    tol_lim;
   csr_index_type        index;

   function automatic logic [COL_W-1:0] clamp_width(logic [DIM_CFG_W-1:0] v);
      logic [WCMP_W-1:0] e;
      e = WCMP_W'(v);
      if (e == '0) return COL_W'(1);
      if (e > WCMP_W'(MaxWidth)) return COL_W'(MaxWidth);
      return COL_W'(e);
   endfunction

   function automatic logic [HGT_W-1:0] clamp_height(logic [DIM_CFG_W-1:0] v);
      logic [HCMP_W-1:0] e;
      e = HCMP_W'(v);
      if (e == '0) return HGT_W'(1);
      if (e > HCMP_W'(MaxHeight)) return HGT_W'(MaxHeight);
      return HGT_W'(e);
   endfunction

   function automatic logic [LINE_W-1:0] clamp_reach(logic [REACH_CFG_W-1:0] v);
      logic [RCMP_W-1:0] e;
      e = RCMP_W'(v);
      if (e > RCMP_W'(HistoryRows - 1)) return LINE_W'(HistoryRows - 1);
      return LINE_W'(e);
   endfunction

   assign index = csr_index_type'(csr_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_width(DIM_CFG_W'(WIDTH_RST));
         height_ff <= clamp_height(DIM_CFG_W'(HEIGHT_RST));
         reach_ff  <= clamp_reach(REACH_CFG_W'(REACH_RST));
         tol_ff    <= TOL_CFG_W'(TOLERANCE_RST);
      end else if (csr_we) begin
         case (index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= clamp_width(csr_wdata[DIM_CFG_W-1:0]);
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= clamp_height(csr_wdata[DIM_CFG_W-1:0]);
            end
            CSR_TOLERANCE_ROWS: begin
               tol_ff <= csr_wdata[TOL_CFG_W-1:0];
            end
            CSR_REACH_ROWS: begin
               reach_ff <= clamp_reach(csr_wdata[REACH_CFG_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // tolerance limited by what the line store has left after the reach
   assign tol_lim = TCMP_W'(HistoryRows - 1) - TCMP_W'(reach_ff);

   always_comb begin
      if (TCMP_W'(tol_ff) > tol_lim) begin
         tol = LINE_W'(tol_lim);
      end else begin
         tol = LINE_W'(tol_ff);
      end
   end

   assign width  = width_ff;
   assign height = height_ff;
   assign reach  = reach_ff;

endmodule

>>> rtl/mvbm_front.sv
// ----------------------------------------------------------------------------
// mvbm_front
// raster counters, line store addressing and per-pixel decode
// ----------------------------------------------------------------------------
`include "mask_vertical_band_marker_defines.svh"

module mvbm_front import mvbm_pkg::*; #(
   parameter int MaxWidth    = MAX_WIDTH_DEF,
   parameter int MaxHeight   = MAX_HEIGHT_DEF,
   parameter int HistoryRows = HISTORY_ROWS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        accept,
   input  req_type                                     req_data,
   input  logic [$clog2(MaxWidth+1)-1:0]               width,
   input  logic [$clog2(MaxHeight+1)-1:0]              height,
   input  logic [$clog2(HistoryRows)-1:0]              reach,
   input  logic [$clog2(HistoryRows)-1:0]              tol,
   output logic [$clog2(HistoryRows*MaxWidth)-1:0]     wr_addr,
   output logic [$clog2(HistoryRows*MaxWidth)-1:0]     rd_addr_cur,
   output logic [$clog2(HistoryRows*MaxWidth)-1:0]     rd_addr_up,
   output logic                                        wr_bit,
   output stage_type                                   stage
);

   localparam int COL_W  = $clog2(MaxWidth + 1);
   localparam int ROW_W  = $clog2(MaxHeight + HistoryRows + 1);
   localparam int LINE_W = $clog2(HistoryRows);
   localparam int ADDR_W = $clog2(HistoryRows * MaxWidth);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic              col_wrap, row_wrap, emit, last;
   logic [COL_W-1:0]  col_a, col_n;
   logic [ROW_W-1:0]  row_p, row_a, row_r, row_lim;
   logic [LINE_W-1:0] line_p, line_a, line_cur, line_up;
   logic [LINE_W:0]   line_wide;

   function automatic logic [LINE_W-1:0] line_inc(logic [LINE_W-1:0] v);
      if ({1'b0, v} == (LINE_W+1)'(HistoryRows - 1)) return '0;
      return v + LINE_W'(1);
   endfunction

   function automatic logic [LINE_W-1:0] line_sub(logic [LINE_W-1:0] a,
                                                 logic [LINE_W-1:0] b);
      if (a >= b) return a - b;
      return LINE_W'({1'b0, a} + (LINE_W+1)'(HistoryRows) - {1'b0, b});
   endfunction

   always_comb begin
      // wrap left over from a configuration change
      col_wrap = col_ff >= width;
      col_a    = col_wrap ? '0 : col_ff;
      row_p    = col_wrap ? row_ff + ROW_W'(1) : row_ff;
      line_p   = col_wrap ? line_inc(line_ff) : line_ff;
      row_lim  = ROW_W'(height) + ROW_W'(reach);
      row_wrap = row_p >= row_lim;
      row_a    = row_wrap ? '0 : row_p;
      line_a   = row_wrap ? '0 : line_p;

      emit     = row_a >= ROW_W'(reach);
      row_r    = row_a - ROW_W'(reach);
      last     = (row_r == ROW_W'(height) - ROW_W'(1)) && (col_a == width - COL_W'(1));
      line_cur = line_sub(line_a, reach);
      line_up  = line_sub(line_cur, tol);

      col_n = col_a + COL_W'(1);
      if (emit && last) begin
         col_in  = '0;
         row_in  = '0;
         line_in = '0;
      end else if (col_n >= width) begin
         col_in  = '0;
         row_in  = row_a + ROW_W'(1);
         line_in = line_inc(line_a);
      end else begin
         col_in  = col_n;
         row_in  = row_a;
         line_in = line_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         line_ff <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         line_ff <= line_in;
      end
   end

   assign wr_bit      = req_data.mask_in & ~req_data.flush;
   assign wr_addr     = ADDR_W'(line_a) * ADDR_W'(MaxWidth) + ADDR_W'(col_a);
   assign rd_addr_cur = ADDR_W'(line_cur) * ADDR_W'(MaxWidth) + ADDR_W'(col_a);
   assign rd_addr_up  = ADDR_W'(line_up) * ADDR_W'(MaxWidth) + ADDR_W'(col_a);

   // same-cycle reads of the slot being written take the new pixel
   always_comb begin
      stage.pix       = wr_bit;
      stage.emit      = emit;
      stage.band_b_ok = row_a < ROW_W'(height);
      stage.tol_ok    = row_r >= ROW_W'(tol);
      stage.byp_cur   = reach == '0;
      stage.byp_up    = (reach == '0) && (tol == '0);
      stage.last      = last;
      stage.row       = POS_OUT_W'(row_r);
      stage.col       = POS_OUT_W'(col_a);
   end

   assign line_wide = {1'b0, line_ff};

   `MVBM_ASSERT_NEXT(a_frame_end_restarts, clock, reset, accept && emit && last, row_ff == '0 && col_ff == '0 && line_ff == '0, "counters not cleared after frame end")
   `MVBM_ASSERT_NEXT(a_counters_hold, clock, reset, !accept, $stable(row_ff) && $stable(col_ff) && $stable(line_ff), "counters moved without a transfer")
   `MVBM_ASSERT_SAME(a_line_in_range, clock, reset, 1'b1, line_wide < (LINE_W+1)'(HistoryRows), "line index beyond line store")

endmodule

>>> rtl/mvbm_back.sv
// ----------------------------------------------------------------------------
// mvbm_back
// band decision on line store data and result register
// ----------------------------------------------------------------------------
`include "mask_vertical_band_marker_defines.svh"

module mvbm_back import mvbm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  stage_type stage,
   input  logic      cur_bit,
   input  logic      up_bit,
   output logic      stage_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   stage_type s1_ff;
   logic      s1_valid_ff, s1_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   logic      out_free, s1_go, cur, up, band;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign s1_go       = s1_valid_ff && (!s1_ff.emit || out_free);
   assign stage_ready = !s1_valid_ff || s1_go;

   always_comb begin
      cur  = s1_ff.byp_cur ? s1_ff.pix : cur_bit;
      up   = s1_ff.byp_up ? s1_ff.pix : up_bit;
      band = (s1_ff.tol_ok && cur && !up) || (s1_ff.band_b_ok && !cur && s1_ff.pix);

      rsp_data_in.mask_out  = band;
      rsp_data_in.out_row   = s1_ff.row;
      rsp_data_in.out_col   = s1_ff.col;
      rsp_data_in.frame_end = s1_ff.last;

      s1_valid_in  = accept || (s1_valid_ff && !s1_go);
      rsp_valid_in = (s1_go && s1_ff.emit) || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (s1_go && s1_ff.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MVBM_ASSERT_NEXT(a_result_loaded, clock, reset, s1_go && s1_ff.emit, rsp_valid_ff, "result lost on its way out")
   `MVBM_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_ff), "stalled stage changed")
   `MVBM_ASSERT_NEXT(a_no_band_outside, clock, reset, s1_go && s1_ff.emit && !s1_ff.tol_ok && !s1_ff.band_b_ok, !rsp_data_ff.mask_out, "band marked where neither test applies")

endmodule

>>> rtl/mask_vertical_band_marker.sv
// ----------------------------------------------------------------------------
// mask_vertical_band_marker
// marks the upper edge band and the outer band above a raster region mask
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req       in    req_valid / req_ready  req_data  (mask_in, flush)
//  rsp       out   rsp_valid / rsp_ready  rsp_data  (mask_out, out_row, out_col, frame_end)
//  csr       in    csr_we                 csr_addr, csr_wdata
//
//  one pixel per clock sustained while rsp_ready holds; a result passes the stage and output registers
//  a pixel gives a result reach_rows rows after it enters, via the line store
//  the line store has one write and two read ports, all used in the transfer cycle
//  reset clears counters and pipeline valids; the line store is not cleared
//  a stalled result stays in the output register while one more pixel is held
// ----------------------------------------------------------------------------
module mask_vertical_band_marker import mvbm_pkg::*; #(
   parameter int MaxWidth    = MAX_WIDTH_DEF,
   parameter int MaxHeight   = MAX_HEIGHT_DEF,
   parameter int HistoryRows = HISTORY_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int COL_W  = $clog2(MaxWidth + 1);
   localparam int HGT_W  = $clog2(MaxHeight + 1);
   localparam int LINE_W = $clog2(HistoryRows);
   localparam int ADDR_W = $clog2(HistoryRows * MaxWidth);

   logic [COL_W-1:0]  width;
   logic [HGT_W-1:0]  height;
   logic [LINE_W-1:0] reach, tol;
   logic [ADDR_W-1:0] wr_addr, rd_addr_cur, rd_addr_up;
   logic              wr_bit, cur_bit, up_bit, accept;
   stage_type         stage;

   assign accept = req_valid && req_ready;

   mvbm_csr #(
      .MaxWidth    (MaxWidth),
      .MaxHeight   (MaxHeight),
      .HistoryRows (HistoryRows)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .width     (width),
      .height    (height),
      .reach     (reach),
      .tol       (tol)
   );

   mvbm_front #(
      .MaxWidth    (MaxWidth),
      .MaxHeight   (MaxHeight),
      .HistoryRows (HistoryRows)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .width       (width),
      .height      (height),
      .reach       (reach),
      .tol         (tol),
      .wr_addr     (wr_addr),
      .rd_addr_cur (rd_addr_cur),
      .rd_addr_up  (rd_addr_up),
      .wr_bit      (wr_bit),
      .stage       (stage)
   );

   mvbm_ram #(
      .Width (1),
      .Depth (HistoryRows * MaxWidth)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wr_addr),
      .wr_data   (wr_bit),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_cur),
      .rd_addr_b (rd_addr_up),
      .rd_data_a (cur_bit),
      .rd_data_b (up_bit)
   );

   mvbm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stage       (stage),
      .cur_bit     (cur_bit),
      .up_bit      (up_bit),
      .stage_ready (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
